[src/ywb_pkg.sv]
package ywb_pkg;

    // Default coordinate width: signed Q15.8
    localparam int COORD_WIDTH_DEF = 24;

    // Yaw is a 16-bit binary angle, 65536 steps to a full turn
    localparam int YAW_WIDTH = 16;
    localparam logic [YAW_WIDTH-1:0] QUARTER_TURN = 16'h4000;

    // Pass-through tags
    localparam int BONE_WIDTH = 8;
    localparam int PART_WIDTH = 4;
    localparam int USER_WIDTH = BONE_WIDTH + PART_WIDTH;

    // Trig values are signed Q1.15 and must hold +1.0 exactly
    localparam int TRIG_WIDTH = 17;
    localparam int FRAC_BITS  = 15;
    localparam int ROUND_HALF = 16384;
    localparam int TRIG_ONE   = 32768;

    // Quarter-wave table segment: 16 segments of 1024 angle steps
    localparam int SEG_BITS = 10;

    typedef logic signed [TRIG_WIDTH-1:0] trig_t;

    typedef struct packed {
        trig_t cos_val;
        trig_t sin_val;
    } sincos_t;

    // round(32768 * sin(k * pi / 32)) for k = 0..16
    function automatic logic [15:0] qsin(input logic [4:0] idx);
        logic [15:0] val;
        case (idx)
            5'd0:    val = 16'd0;
            5'd1:    val = 16'd3212;
            5'd2:    val = 16'd6393;
            5'd3:    val = 16'd9512;
            5'd4:    val = 16'd12540;
            5'd5:    val = 16'd15447;
            5'd6:    val = 16'd18205;
            5'd7:    val = 16'd20788;
            5'd8:    val = 16'd23170;
            5'd9:    val = 16'd25330;
            5'd10:   val = 16'd27246;
            5'd11:   val = 16'd28899;
            5'd12:   val = 16'd30274;
            5'd13:   val = 16'd31357;
            5'd14:   val = 16'd32138;
            5'd15:   val = 16'd32610;
            default: val = 16'd32768;
        endcase
        return val;
    endfunction

endpackage

[src/yaw_rotated_box_world_bounds.sv]
// Yaw-rotated box to world bounds. Each input transaction carries one local
// axis-aligned box (min and max corners), a world origin and a 16-bit binary
// yaw angle; the block rotates the box about Z, translates it by the origin
// and returns the axis-aligned world box that encloses all eight corners,
// saturated to the signed coordinate range, with the bone and part tags
// copied through. Sine and cosine come from a 17-entry quarter-wave table
// with linear interpolation, and corner sums round half toward plus
// infinity. The datapath is a four-register pipeline (input register,
// sine/cosine register, product register, result register), so one box can be
// taken every cycle while the output side does not stall; m_tvalid is the
// valid bit of the result register. Each stage holds while the stage after
// it is full and stalled; an empty stage still takes data, so m_tready low
// drops s_tready only once every stage is full. The block keeps no state
// between boxes.
module yaw_rotated_box_world_bounds #(
    parameter int COORD_WIDTH = ywb_pkg::COORD_WIDTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,

    // s_tdata, low bit up: local_min_x, local_min_y, local_min_z,
    // local_max_x, local_max_y, local_max_z, origin_x, origin_y, origin_z,
    // yaw_angle, zero fill to whole bytes
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((9*COORD_WIDTH+ywb_pkg::YAW_WIDTH+7)/8)*8-1:0] s_tdata,
    // s_tuser, low bit up: bone_tag, part_tag
    input  logic [ywb_pkg::USER_WIDTH-1:0]        s_tuser,

    // m_tdata, low bit up: world_min_x, world_min_y, world_min_z,
    // world_max_x, world_max_y, world_max_z, zero fill to whole bytes
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((6*COORD_WIDTH+7)/8)*8-1:0]    m_tdata,
    // m_tuser, low bit up: bone_out, part_out
    output logic [ywb_pkg::USER_WIDTH-1:0]        m_tuser
);

    localparam int CW        = COORD_WIDTH;
    localparam int PW        = CW + ywb_pkg::TRIG_WIDTH;
    localparam int IN_BITS   = 9 * CW + ywb_pkg::YAW_WIDTH;
    localparam int OUT_BITS  = 6 * CW;
    localparam int OUT_TDW   = ((OUT_BITS + 7) / 8) * 8;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [PW-1:0] prod_t;

    // ---------------------------------------------------------------
    // Pipeline flow control: a stage advances when it is empty or when
    // the stage after it is taking its contents.
    // ---------------------------------------------------------------
    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic v0_next, v1_next, v2_next, v3_next;
    logic rdy0, rdy1, rdy2, rdy3;

    assign rdy3 = !v3_reg || m_tready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign rdy0 = !v0_reg || rdy1;

    assign s_tready = rdy0;

    always_comb begin
        v0_next = rdy0 ? s_tvalid : v0_reg;
        v1_next = rdy1 ? v0_reg   : v1_reg;
        v2_next = rdy2 ? v1_reg   : v2_reg;
        v3_next = rdy3 ? v2_reg   : v3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: input register
    // ---------------------------------------------------------------
    logic [IN_BITS-1:0]             in_data_reg;
    logic [ywb_pkg::USER_WIDTH-1:0] in_user_reg;

    always_ff @(posedge aclk) begin
        if (rdy0 && s_tvalid) begin
            in_data_reg <= s_tdata[IN_BITS-1:0];
            in_user_reg <= s_tuser;
        end
    end

    logic [ywb_pkg::YAW_WIDTH-1:0] yaw0;
    ywb_pkg::sincos_t              trig0;

    assign yaw0 = in_data_reg[9*CW +: ywb_pkg::YAW_WIDTH];

    ywb_sincos u_sincos (
        .yaw  (yaw0),
        .trig (trig0)
    );

    // ---------------------------------------------------------------
    // Stage 1: sine/cosine register, coordinates carried alongside
    // ---------------------------------------------------------------
    ywb_pkg::sincos_t               cs_reg;
    logic [9*CW-1:0]                crd1_reg;
    logic [ywb_pkg::USER_WIDTH-1:0] user1_reg;

    always_ff @(posedge aclk) begin
        if (rdy1 && v0_reg) begin
            cs_reg    <= trig0;
            crd1_reg  <= in_data_reg[9*CW-1:0];
            user1_reg <= in_user_reg;
        end
    end

    coord_t lo_x1, lo_y1, hi_x1, hi_y1;
    prod_t  lox_c1, hix_c1, lox_s1, hix_s1, loy_c1, hiy_c1, loy_s1, hiy_s1;

    assign lo_x1 = $signed(crd1_reg[0*CW +: CW]);
    assign lo_y1 = $signed(crd1_reg[1*CW +: CW]);
    assign hi_x1 = $signed(crd1_reg[3*CW +: CW]);
    assign hi_y1 = $signed(crd1_reg[4*CW +: CW]);

    ywb_rotate #(
        .COORD_WIDTH (CW)
    ) u_rotate (
        .lo_x  (lo_x1),
        .hi_x  (hi_x1),
        .lo_y  (lo_y1),
        .hi_y  (hi_y1),
        .trig  (cs_reg),
        .lox_c (lox_c1),
        .hix_c (hix_c1),
        .lox_s (lox_s1),
        .hix_s (hix_s1),
        .loy_c (loy_c1),
        .hiy_c (hiy_c1),
        .loy_s (loy_s1),
        .hiy_s (hiy_s1)
    );

    // ---------------------------------------------------------------
    // Stage 2: product register, z bounds and origin carried alongside
    // ---------------------------------------------------------------
    prod_t  lox_c_reg, hix_c_reg, lox_s_reg, hix_s_reg;
    prod_t  loy_c_reg, hiy_c_reg, loy_s_reg, hiy_s_reg;
    coord_t lo_z_reg, hi_z_reg, org_x_reg, org_y_reg, org_z_reg;
    logic [ywb_pkg::USER_WIDTH-1:0] user2_reg;

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            lox_c_reg <= lox_c1;
            hix_c_reg <= hix_c1;
            lox_s_reg <= lox_s1;
            hix_s_reg <= hix_s1;
            loy_c_reg <= loy_c1;
            hiy_c_reg <= hiy_c1;
            loy_s_reg <= loy_s1;
            hiy_s_reg <= hiy_s1;
            lo_z_reg  <= $signed(crd1_reg[2*CW +: CW]);
            hi_z_reg  <= $signed(crd1_reg[5*CW +: CW]);
            org_x_reg <= $signed(crd1_reg[6*CW +: CW]);
            org_y_reg <= $signed(crd1_reg[7*CW +: CW]);
            org_z_reg <= $signed(crd1_reg[8*CW +: CW]);
            user2_reg <= user1_reg;
        end
    end

    coord_t min_x2, min_y2, min_z2, max_x2, max_y2, max_z2;

    ywb_extent #(
        .COORD_WIDTH (CW)
    ) u_extent (
        .lox_c (lox_c_reg),
        .hix_c (hix_c_reg),
        .lox_s (lox_s_reg),
        .hix_s (hix_s_reg),
        .loy_c (loy_c_reg),
        .hiy_c (hiy_c_reg),
        .loy_s (loy_s_reg),
        .hiy_s (hiy_s_reg),
        .lo_z  (lo_z_reg),
        .hi_z  (hi_z_reg),
        .org_x (org_x_reg),
        .org_y (org_y_reg),
        .org_z (org_z_reg),
        .min_x (min_x2),
        .min_y (min_y2),
        .min_z (min_z2),
        .max_x (max_x2),
        .max_y (max_y2),
        .max_z (max_z2)
    );

    // ---------------------------------------------------------------
    // Stage 3: result register, holds while the output is stalled
    // ---------------------------------------------------------------
    coord_t out_min_x_reg, out_min_y_reg, out_min_z_reg;
    coord_t out_max_x_reg, out_max_y_reg, out_max_z_reg;
    logic [ywb_pkg::USER_WIDTH-1:0] out_user_reg;

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            out_min_x_reg <= min_x2;
            out_min_y_reg <= min_y2;
            out_min_z_reg <= min_z2;
            out_max_x_reg <= max_x2;
            out_max_y_reg <= max_y2;
            out_max_z_reg <= max_z2;
            out_user_reg  <= user2_reg;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = OUT_TDW'({out_max_z_reg, out_max_y_reg, out_max_x_reg,
                                out_min_z_reg, out_min_y_reg, out_min_x_reg});
    assign m_tuser  = out_user_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_bounds_x: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_min_x_reg <= out_max_x_reg))
        else $error("world x bounds inverted");

    a_bounds_y: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_min_y_reg <= out_max_y_reg))
        else $error("world y bounds inverted");

    a_bounds_z: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_min_z_reg <= out_max_z_reg))
        else $error("world z bounds inverted");

    a_trig_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg |-> (cs_reg.cos_val <= ywb_pkg::trig_t'(ywb_pkg::TRIG_ONE)
                 && cs_reg.cos_val >= -ywb_pkg::trig_t'(ywb_pkg::TRIG_ONE)
                 && cs_reg.sin_val <= ywb_pkg::trig_t'(ywb_pkg::TRIG_ONE)
                 && cs_reg.sin_val >= -ywb_pkg::trig_t'(ywb_pkg::TRIG_ONE)))
        else $error("sine or cosine outside unit range");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !m_tready && v2_reg) |=> (v2_reg && v3_reg))
        else $error("pipeline dropped a box under output stall");

endmodule

[src/ywb_sincos.sv]
module ywb_sincos (
    input  logic [ywb_pkg::YAW_WIDTH-1:0] yaw,
    output ywb_pkg::sincos_t              trig
);

    // Magnitude for a quarter angle 0..16384: table plus linear interpolation
    function automatic logic [15:0] quarter_mag(input logic [14:0] r);
        logic [4:0]  seg;
        logic [9:0]  frac;
        logic [15:0] base;
        logic [11:0] delta;
        logic [21:0] prod;
        logic [22:0] acc;
        logic [15:0] mag;
        seg   = r[14:10];
        frac  = r[ywb_pkg::SEG_BITS-1:0];
        base  = ywb_pkg::qsin(seg);
        delta = 12'(ywb_pkg::qsin(5'(seg + 5'd1)) - base);
        prod  = 22'(delta) * 22'(frac);
        acc   = 23'(prod) + 23'd512;
        if (seg[4]) begin
            mag = ywb_pkg::qsin(seg);
        end else begin
            mag = base + 16'(acc >> ywb_pkg::SEG_BITS);
        end
        return mag;
    endfunction

    function automatic ywb_pkg::trig_t sine_of(input logic [ywb_pkg::YAW_WIDTH-1:0] a);
        logic [1:0]     quad;
        logic [14:0]    r;
        logic [14:0]    arg;
        ywb_pkg::trig_t val;
        quad = a[15:14];
        r    = {1'b0, a[13:0]};
        arg  = quad[0] ? 15'(15'd16384 - r) : r;
        val  = ywb_pkg::trig_t'({1'b0, quarter_mag(arg)});
        return quad[1] ? -val : val;
    endfunction

    assign trig.sin_val = sine_of(yaw);
    assign trig.cos_val = sine_of(yaw + ywb_pkg::QUARTER_TURN);

endmodule

[src/ywb_rotate.sv]
module ywb_rotate #(
    parameter int COORD_WIDTH = ywb_pkg::COORD_WIDTH_DEF
) (
    input  logic signed [COORD_WIDTH-1:0]                     lo_x,
    input  logic signed [COORD_WIDTH-1:0]                     hi_x,
    input  logic signed [COORD_WIDTH-1:0]                     lo_y,
    input  logic signed [COORD_WIDTH-1:0]                     hi_y,
    input  ywb_pkg::sincos_t                                  trig,
    output logic signed [COORD_WIDTH+ywb_pkg::TRIG_WIDTH-1:0] lox_c,
    output logic signed [COORD_WIDTH+ywb_pkg::TRIG_WIDTH-1:0] hix_c,
    output logic signed [COORD_WIDTH+ywb_pkg::TRIG_WIDTH-1:0] lox_s,
    output logic signed [COORD_WIDTH+ywb_pkg::TRIG_WIDTH-1:0] hix_s,
    output logic signed [COORD_WIDTH+ywb_pkg::TRIG_WIDTH-1:0] loy_c,
    output logic signed [COORD_WIDTH+ywb_pkg::TRIG_WIDTH-1:0] hiy_c,
    output logic signed [COORD_WIDTH+ywb_pkg::TRIG_WIDTH-1:0] loy_s,
    output logic signed [COORD_WIDTH+ywb_pkg::TRIG_WIDTH-1:0] hiy_s
);

    // Both corner values on the x and y axes times cos and sin, exact
    assign lox_c = lo_x * trig.cos_val;
    assign hix_c = hi_x * trig.cos_val;
    assign lox_s = lo_x * trig.sin_val;
    assign hix_s = hi_x * trig.sin_val;
    assign loy_c = lo_y * trig.cos_val;
    assign hiy_c = hi_y * trig.cos_val;
    assign loy_s = lo_y * trig.sin_val;
    assign hiy_s = hi_y * trig.sin_val;

endmodule

[src/ywb_extent.sv]
module ywb_extent #(
    parameter int COORD_WIDTH = ywb_pkg::COORD_WIDTH_DEF
) (
    input  logic signed [COORD_WIDTH+ywb_pkg::TRIG_WIDTH-1:0] lox_c,
    input  logic signed [COORD_WIDTH+ywb_pkg::TRIG_WIDTH-1:0] hix_c,
    input  logic signed [COORD_WIDTH+ywb_pkg::TRIG_WIDTH-1:0] lox_s,
    input  logic signed [COORD_WIDTH+ywb_pkg::TRIG_WIDTH-1:0] hix_s,
    input  logic signed [COORD_WIDTH+ywb_pkg::TRIG_WIDTH-1:0] loy_c,
    input  logic signed [COORD_WIDTH+ywb_pkg::TRIG_WIDTH-1:0] hiy_c,
    input  logic signed [COORD_WIDTH+ywb_pkg::TRIG_WIDTH-1:0] loy_s,
    input  logic signed [COORD_WIDTH+ywb_pkg::TRIG_WIDTH-1:0] hiy_s,
    input  logic signed [COORD_WIDTH-1:0]                     lo_z,
    input  logic signed [COORD_WIDTH-1:0]                     hi_z,
    input  logic signed [COORD_WIDTH-1:0]                     org_x,
    input  logic signed [COORD_WIDTH-1:0]                     org_y,
    input  logic signed [COORD_WIDTH-1:0]                     org_z,
    output logic signed [COORD_WIDTH-1:0]                     min_x,
    output logic signed [COORD_WIDTH-1:0]                     min_y,
    output logic signed [COORD_WIDTH-1:0]                     min_z,
    output logic signed [COORD_WIDTH-1:0]                     max_x,
    output logic signed [COORD_WIDTH-1:0]                     max_y,
    output logic signed [COORD_WIDTH-1:0]                     max_z
);

    localparam int PW = COORD_WIDTH + ywb_pkg::TRIG_WIDTH;
    localparam int SW = PW + 1;
    localparam int RW = SW - ywb_pkg::FRAC_BITS;
    localparam int WW = COORD_WIDTH + 4;

    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [SW-1:0] sum_t;
    typedef logic signed [RW-1:0] rnd_t;
    typedef logic signed [WW-1:0] wide_t;

    // floor((v + half) / 2^15): half rounds toward plus infinity
    function automatic rnd_t round_q15(input sum_t v);
        sum_t t;
        t = v + SW'(ywb_pkg::ROUND_HALF);
        return $signed(t[SW-1:ywb_pkg::FRAC_BITS]);
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] sat_coord(input wide_t v);
        logic signed [COORD_WIDTH-1:0] res;
        if (v[WW-1:COORD_WIDTH-1] != {(WW-COORD_WIDTH+1){v[WW-1]}}) begin
            res = {v[WW-1], {(COORD_WIDTH-1){~v[WW-1]}}};
        end else begin
            res = v[COORD_WIDTH-1:0];
        end
        return res;
    endfunction

    prod_t xc_min, xc_max, ys_min, ys_max;
    prod_t xs_min, xs_max, yc_min, yc_max;
    sum_t  sum_xmin, sum_xmax, sum_ymin, sum_ymax;
    logic signed [COORD_WIDTH-1:0] z_min, z_max;

    // Rounding, translation and saturation are all monotone, so the extreme
    // corners come from the extreme products on each term
    assign xc_min = (lox_c < hix_c) ? lox_c : hix_c;
    assign xc_max = (lox_c < hix_c) ? hix_c : lox_c;
    assign ys_min = (loy_s < hiy_s) ? loy_s : hiy_s;
    assign ys_max = (loy_s < hiy_s) ? hiy_s : loy_s;
    assign xs_min = (lox_s < hix_s) ? lox_s : hix_s;
    assign xs_max = (lox_s < hix_s) ? hix_s : lox_s;
    assign yc_min = (loy_c < hiy_c) ? loy_c : hiy_c;
    assign yc_max = (loy_c < hiy_c) ? hiy_c : loy_c;
    assign z_min  = (lo_z < hi_z) ? lo_z : hi_z;
    assign z_max  = (lo_z < hi_z) ? hi_z : lo_z;

    assign sum_xmin = SW'(xc_min) - SW'(ys_max);
    assign sum_xmax = SW'(xc_max) - SW'(ys_min);
    assign sum_ymin = SW'(xs_min) + SW'(yc_min);
    assign sum_ymax = SW'(xs_max) + SW'(yc_max);

    assign min_x = sat_coord(WW'(round_q15(sum_xmin)) + WW'(org_x));
    assign max_x = sat_coord(WW'(round_q15(sum_xmax)) + WW'(org_x));
    assign min_y = sat_coord(WW'(round_q15(sum_ymin)) + WW'(org_y));
    assign max_y = sat_coord(WW'(round_q15(sum_ymax)) + WW'(org_y));
    assign min_z = sat_coord(WW'(z_min) + WW'(org_z));
    assign max_z = sat_coord(WW'(z_max) + WW'(org_z));

endmodule

[tb/sv/box_bounds_checker.sv]
module box_bounds_checker #(
    parameter int CW = ywb_pkg::COORD_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [((9*CW+ywb_pkg::YAW_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic [ywb_pkg::USER_WIDTH-1:0]    s_tuser,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [((6*CW+7)/8)*8-1:0]         m_tdata,
    input  logic [ywb_pkg::USER_WIDTH-1:0]    m_tuser,
    output int                                boxes_outstanding,
    output int                                mismatches
);

    localparam int S_W = ((9*CW+ywb_pkg::YAW_WIDTH+7)/8)*8;
    localparam int BW  = ywb_pkg::BONE_WIDTH;
    localparam int UW  = ywb_pkg::USER_WIDTH;
    localparam longint COORD_MAX = (longint'(1) << (CW-1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    // bounds[0..2] world min x/y/z, bounds[3..5] world max x/y/z
    typedef struct packed {
        logic [ywb_pkg::PART_WIDTH-1:0] part;
        logic [BW-1:0]                  bone;
        logic [5:0][CW-1:0]             bounds;
    } world_box_t;

    world_box_t expected_boxes[$];
    world_box_t oldest;
    int         sine_table [0:16];
    string      bound_names [0:5];
    int         result_index;

    initial begin
        sine_table = '{0, 3212, 6393, 9512, 12540, 15447, 18205, 20788, 23170,
                       25330, 27246, 28899, 30274, 31357, 32138, 32610, 32768};
        bound_names = '{"world_min_x", "world_min_y", "world_min_z",
                        "world_max_x", "world_max_y", "world_max_z"};
        boxes_outstanding = 0;
        mismatches = 0;
        result_index = 0;
    end

    // interpolated magnitude over one quarter turn
    function automatic int quarter_mag(input int r);
        int i;
        int f;
        i = r >> ywb_pkg::SEG_BITS;
        f = r & ((1 << ywb_pkg::SEG_BITS) - 1);
        if (i >= 16) return sine_table[16];
        return sine_table[i] + (((sine_table[i+1] - sine_table[i]) * f + 512)
                                >> ywb_pkg::SEG_BITS);
    endfunction

    function automatic int sine_q15(input logic [15:0] a);
        int m;
        m = a[14] ? quarter_mag(16384 - int'(a[13:0])) : quarter_mag(int'(a[13:0]));
        return a[15] ? -m : m;
    endfunction

    function automatic longint clamp_coord(input longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    // round half toward plus infinity, back to coordinate units
    function automatic longint round_q15(input longint v);
        return (v + ywb_pkg::ROUND_HALF) >>> ywb_pkg::FRAC_BITS;
    endfunction

    function automatic world_box_t enclose_rotated_box(input logic [S_W-1:0] d,
                                                       input logic [UW-1:0] u);
        longint     lo[3], hi[3], org[3], w[3], wmin[3], wmax[3];
        longint     c, s, lx, ly, lz;
        logic [15:0] yaw, cos_angle;
        world_box_t r;
        yaw = d[9*CW +: 16];
        cos_angle = yaw + ywb_pkg::QUARTER_TURN;
        c = sine_q15(cos_angle);
        s = sine_q15(yaw);
        for (int k = 0; k < 3; k++) begin
            lo[k]  = longint'(signed'(d[k*CW +: CW]));
            hi[k]  = longint'(signed'(d[(3+k)*CW +: CW]));
            org[k] = longint'(signed'(d[(6+k)*CW +: CW]));
        end
        for (int j = 0; j < 8; j++) begin
            lx = (j & 1) ? hi[0] : lo[0];
            ly = (j & 2) ? hi[1] : lo[1];
            lz = (j & 4) ? hi[2] : lo[2];
            w[0] = clamp_coord(round_q15(lx * c - ly * s) + org[0]);
            w[1] = clamp_coord(round_q15(lx * s + ly * c) + org[1]);
            w[2] = clamp_coord(lz + org[2]);
            for (int k = 0; k < 3; k++) begin
                if (j == 0 || w[k] < wmin[k]) wmin[k] = w[k];
                if (j == 0 || w[k] > wmax[k]) wmax[k] = w[k];
            end
        end
        for (int k = 0; k < 3; k++) begin
            r.bounds[k]   = wmin[k][CW-1:0];
            r.bounds[3+k] = wmax[k][CW-1:0];
        end
        r.bone = u[BW-1:0];
        r.part = u[UW-1:BW];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("ERROR result %0d: %s got %0d expected %0d", result_index, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_boxes.size() == 0) begin
                    report_mismatch("unexpected transaction, outstanding count",
                                    longint'(0), longint'(0));
                end else begin
                    oldest = expected_boxes.pop_front();
                    for (int k = 0; k < 6; k++)
                        if (m_tdata[k*CW +: CW] !== oldest.bounds[k])
                            report_mismatch(bound_names[k],
                                            longint'(signed'(m_tdata[k*CW +: CW])),
                                            longint'(signed'(oldest.bounds[k])));
                    if (m_tuser[BW-1:0] !== oldest.bone)
                        report_mismatch("bone_out", longint'(m_tuser[BW-1:0]),
                                        longint'(oldest.bone));
                    if (m_tuser[UW-1:BW] !== oldest.part)
                        report_mismatch("part_out", longint'(m_tuser[UW-1:BW]),
                                        longint'(oldest.part));
                end
                result_index++;
            end
            if (s_tvalid && s_tready)
                expected_boxes.insert(expected_boxes.size(),
                                      enclose_rotated_box(s_tdata, s_tuser));
            boxes_outstanding <= expected_boxes.size();
        end
    end

endmodule

[tb/sv/yaw_rotated_box_world_bounds_tb.sv]
module yaw_rotated_box_world_bounds_tb;

    localparam int CW  = ywb_pkg::COORD_WIDTH_DEF;
    localparam int S_W = ((9*CW+ywb_pkg::YAW_WIDTH+7)/8)*8;
    localparam int M_W = ((6*CW+7)/8)*8;
    localparam int UW  = ywb_pkg::USER_WIDTH;
    localparam int BW  = ywb_pkg::BONE_WIDTH;

    // random boxes after the directed set
    localparam int RANDOM_BOXES = 1330;
    // watchdog limit, kept well above the slowest run with both sides idling
    localparam int CYCLE_LIMIT  = 200000;

    localparam int COORD_TOP = (1 << (CW-1)) - 1;
    localparam int COORD_BOT = -(1 << (CW-1));

    logic           aclk;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    // s_tdata, low bit up: local_min_x/y/z, local_max_x/y/z, origin_x/y/z, yaw_angle
    logic [S_W-1:0] s_tdata;
    // s_tuser, low bit up: bone_tag, part_tag
    logic [UW-1:0]  s_tuser;
    logic           m_tvalid;
    logic           m_tready;
    // m_tdata, low bit up: world_min_x/y/z, world_max_x/y/z
    logic [M_W-1:0] m_tdata;
    // m_tuser, low bit up: bone_out, part_out
    logic [UW-1:0]  m_tuser;

    int boxes_outstanding;
    int mismatches;
    int send_idle_pct;
    int recv_idle_pct;
    int cycle_count;

    yaw_rotated_box_world_bounds #(
        .COORD_WIDTH(CW)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    box_bounds_checker #(
        .CW(CW)
    ) checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tuser           (m_tuser),
        .boxes_outstanding (boxes_outstanding),
        .mismatches        (mismatches)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Receiver: drop m_tready on a random share of cycles, set by the phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // Watchdog: count cycles and give up well past the slowest correct run.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Offer one box; idle first on a random share of cycles, then hold the
    // transaction until the block takes it. Coordinates are truncated to CW bits.
    task automatic send_box(input int x0, input int y0, input int z0,
                            input int x1, input int y1, input int z1,
                            input int ox, input int oy, input int oz,
                            input int yaw, input int bone, input int part);
        logic [S_W-1:0] word;
        word = '0;
        word[9*CW+15:0] = {yaw[15:0], oz[CW-1:0], oy[CW-1:0], ox[CW-1:0],
                           z1[CW-1:0], y1[CW-1:0], x1[CW-1:0],
                           z0[CW-1:0], y0[CW-1:0], x0[CW-1:0]};
        if ($urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99, 0) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= {part[3:0], bone[BW-1:0]};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Lower valid and hold off until every outstanding box has come back.
    // The first edge lets the checker count the last accepted transaction.
    task automatic drain_boxes();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (boxes_outstanding != 0);
    endtask

    function automatic int small_coord();
        return int'($urandom_range(8191, 0)) - 4096;
    endfunction

    function automatic int signed_span(input int mag);
        return int'($urandom_range(2*mag, 0)) - mag;
    endfunction

    // Random box, weighted toward ordered boxes of modest size so rotation
    // stays inside range, with full-range noise, inverted boxes, boxes pushed
    // against saturation and yaws on table points and quadrant edges.
    task automatic random_box();
        int kind;
        int lo[3];
        int hi[3];
        int org[3];
        int yaw;
        int tmp;
        kind = $urandom_range(9, 0);
        yaw  = $urandom_range(65535, 0);
        for (int k = 0; k < 3; k++) begin
            lo[k]  = $urandom;
            hi[k]  = $urandom;
            org[k] = $urandom;
        end
        if (kind >= 4 && kind <= 8) begin
            for (int k = 0; k < 3; k++) begin
                lo[k]  = small_coord();
                hi[k]  = lo[k] + int'($urandom_range(8191, 0));
                org[k] = signed_span(1 << 20);
            end
        end
        case (kind)
            6: begin
                // push the origin against either end of the range
                for (int k = 0; k < 3; k++)
                    org[k] = $urandom_range(1, 0) ? COORD_TOP - int'($urandom_range(4095, 0))
                                                  : COORD_BOT + int'($urandom_range(4095, 0));
            end
            7: begin
                // swap min and max on every axis
                for (int k = 0; k < 3; k++) begin
                    tmp = lo[k];
                    lo[k] = hi[k];
                    hi[k] = tmp;
                end
            end
            8: begin
                // table points and their neighbors, quadrant edges included
                yaw = (int'($urandom_range(63, 0)) * 1024 + int'($urandom_range(2, 0)) - 1)
                      & 16'hFFFF;
            end
            9: begin
                for (int k = 0; k < 3; k++) begin
                    lo[k] = -int'($urandom_range(COORD_TOP, 1 << (CW-2)));
                    hi[k] = int'($urandom_range(COORD_TOP, 1 << (CW-2)));
                end
            end
            default: ;
        endcase
        send_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], org[0], org[1], org[2],
                 yaw, $urandom_range(255, 0), $urandom_range(15, 0));
    endtask

    initial begin
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tuser       <= '0;
        m_tready      <= 1'b0;
        aresetn       <= 1'b0;
        send_idle_pct = 29;
        recv_idle_pct = 48;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed set.
        // all zero, yaw zero: identity on a point
        send_box(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // yaw zero is exact: plain translation
        send_box(-100, -200, -300, 400, 500, 600, 1000, -2000, 3000, 0, 255, 15);
        // quadrant boundaries and the last angle before a full turn
        send_box(-100, -200, -300, 400, 500, 600, 0, 0, 0, 16'h4000, 1, 1);
        send_box(-100, -200, -300, 400, 500, 600, 0, 0, 0, 16'h8000, 2, 2);
        send_box(-100, -200, -300, 400, 500, 600, 0, 0, 0, 16'hC000, 4, 4);
        send_box(-100, -200, -300, 400, 500, 600, 0, 0, 0, 16'hFFFF, 8, 8);
        // forty-five degrees, a table point, just short of a quadrant edge and just short of a table point
        send_box(-5000, -7000, 10, 9000, 3000, 20, 0, 0, 0, 16'h2000, 16, 3);
        send_box(-5000, -7000, 10, 9000, 3000, 20, 0, 0, 0, 16'h0400, 32, 5);
        send_box(-5000, -7000, 10, 9000, 3000, 20, 0, 0, 0, 16'h3FFF, 64, 6);
        send_box(-5000, -7000, 10, 9000, 3000, 20, 0, 0, 0, 16'h03FF, 128, 7);
        // exact half in x rounds toward plus infinity, on both signs
        send_box(-8192, 0, 0, 8192, 0, 0, 0, 0, 0, 16'h1000, 170, 10);
        // full-range box at forty-five degrees saturates both ends
        send_box(COORD_BOT, COORD_BOT, COORD_BOT, COORD_TOP, COORD_TOP, COORD_TOP,
                 0, 0, 0, 16'h2000, 85, 5);
        // extreme origins saturate a small box
        send_box(-10, -10, -10, 10, 10, 10, COORD_TOP, COORD_TOP, COORD_TOP,
                 16'h1234, 255, 15);
        send_box(-10, -10, -10, 10, 10, 10, COORD_BOT, COORD_BOT, COORD_BOT,
                 16'h9876, 0, 0);
        // full-range box plus full-range origin
        send_box(COORD_BOT, COORD_BOT, COORD_BOT, COORD_TOP, COORD_TOP, COORD_TOP,
                 COORD_TOP, COORD_BOT, COORD_TOP, 16'h6000, 204, 12);
        send_box(COORD_TOP, COORD_TOP, COORD_TOP, COORD_BOT, COORD_BOT, COORD_BOT,
                 COORD_BOT, COORD_TOP, COORD_BOT, 16'hE000, 51, 3);
        // inverted box: min above max on every axis
        send_box(700, 800, 900, -700, -800, -900, 50, 60, 70, 16'h1555, 99, 9);
        // degenerate box at the negative extreme, all ones tags
        send_box(COORD_BOT, COORD_BOT, COORD_BOT, COORD_BOT, COORD_BOT, COORD_BOT,
                 0, 0, 0, 16'h8000, 255, 15);

        // Pause the sender until the pipeline is empty.
        drain_boxes();

        // Random phases: sender idles less than the receiver, then the other
        // way round, then neither idles.
        for (int n = 0; n < RANDOM_BOXES; n++) begin
            if (n == RANDOM_BOXES / 3) begin
                drain_boxes();
                send_idle_pct = 48;
                recv_idle_pct = 29;
            end else if (n == 2 * RANDOM_BOXES / 3) begin
                drain_boxes();
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_box();
        end

        // Flush: wait out every outstanding box, then let the pipeline settle.
        drain_boxes();
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
src/ywb_pkg.sv
src/ywb_sincos.sv
src/ywb_rotate.sv
src/ywb_extent.sv
src/yaw_rotated_box_world_bounds.sv
tb/sv/box_bounds_checker.sv
tb/sv/yaw_rotated_box_world_bounds_tb.sv
